// File: sv/dpes_pkg.sv
`timescale 1ns / 1ps

package dpes_pkg;

   // Register widths fixed by the drive's object dictionary
   localparam int WORD_BITS  = 16;
   localparam int POS_BITS   = 32;
   localparam int TIMER_BITS_DEFAULT = 16;

   // CSR register indexes
   localparam logic [1:0] CSR_STEP_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_SETTLE       = 2'd1;
   localparam logic [1:0] CSR_FAULT_PULSE  = 2'd2;

   localparam logic [WORD_BITS-1:0] STEP_TIMEOUT_RESET = 16'd2000;
   localparam logic [WORD_BITS-1:0] SETTLE_RESET       = 16'd100;
   localparam logic [WORD_BITS-1:0] FAULT_PULSE_RESET  = 16'd20;

   // Request modes
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_ENABLE  = 2'd1;
   localparam logic [1:0] MODE_DISABLE = 2'd2;

   // Controlwords
   localparam logic [WORD_BITS-1:0] CW_OFF                  = 16'h0000;
   localparam logic [WORD_BITS-1:0] CW_SHUTDOWN             = 16'h0006;
   localparam logic [WORD_BITS-1:0] CW_SWITCH_ON            = 16'h0007;
   localparam logic [WORD_BITS-1:0] CW_ENABLE_OP            = 16'h000F;
   localparam logic [WORD_BITS-1:0] CW_FAULT_RESET_SHUTDOWN = 16'h0086;
   localparam logic [WORD_BITS-1:0] CW_FINAL                = 16'h001F;

   localparam logic [WORD_BITS-1:0] ERR_CLEARABLE = 16'h2000;

   // Sequence status codes
   localparam logic [2:0] STS_IDLE     = 3'd0;
   localparam logic [2:0] STS_BUSY     = 3'd1;
   localparam logic [2:0] STS_DONE     = 3'd2;
   localparam logic [2:0] STS_REJECTED = 3'd3;
   localparam logic [2:0] STS_TIMEOUT  = 3'd4;

   // Decoded drive states
   localparam logic [3:0] ST_UNKNOWN        = 4'd0;
   localparam logic [3:0] ST_NOT_READY      = 4'd1;
   localparam logic [3:0] ST_DISABLED       = 4'd2;
   localparam logic [3:0] ST_READY          = 4'd3;
   localparam logic [3:0] ST_ON             = 4'd4;
   localparam logic [3:0] ST_ENABLED        = 4'd5;
   localparam logic [3:0] ST_QUICKSTOP      = 4'd6;
   localparam logic [3:0] ST_FAULT_REACTION = 4'd7;
   localparam logic [3:0] ST_FAULT          = 4'd8;

   localparam logic [WORD_BITS-1:0] SW_MASK_WIDE   = 16'h006F;
   localparam logic [WORD_BITS-1:0] SW_MASK_NARROW = 16'h004F;
   localparam int SW_FAULT_BIT = 3;

   typedef struct packed {
      logic [1:0]                  mode;
      logic [WORD_BITS-1:0]        status_word;
      logic [WORD_BITS-1:0]        drive_error_code;
      logic signed [POS_BITS-1:0]  actual_position;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]        control_word;
      logic                        target_write;
      logic signed [POS_BITS-1:0]  target_position;
      logic [2:0]                  sequence_status;
      logic [3:0]                  decoded_state;
      logic                        fault_seen;
   } rsp_type;

   function automatic logic [3:0] decode_state(input logic [WORD_BITS-1:0] sw);
      logic [WORD_BITS-1:0] wide;
      logic [WORD_BITS-1:0] narrow;
      logic [3:0]           st;
      wide   = sw & SW_MASK_WIDE;
      narrow = sw & SW_MASK_NARROW;
      if (wide == 16'h0021) st = ST_READY;
      else if (wide == 16'h0023) st = ST_ON;
      else if (wide == 16'h0027) st = ST_ENABLED;
      else if (wide == 16'h0007) st = ST_QUICKSTOP;
      else if (narrow == 16'h0000) st = ST_NOT_READY;
      else if (narrow == 16'h0040) st = ST_DISABLED;
      else if (narrow == 16'h000F) st = ST_FAULT_REACTION;
      else if (narrow == 16'h0008) st = ST_FAULT;
      else st = ST_UNKNOWN;
      return st;
   endfunction

endpackage

// File: sv/dpes_rsp_buffer.sv
`timescale 1ns / 1ps

module dpes_rsp_buffer
   import dpes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    out_free;

   // output slot can take a new transaction this cycle
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         // hold the stalled result, park the new one
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: sv/drive_power_enable_sequencer_unit.sv
`timescale 1ns / 1ps
// Each accepted request's result is registered in the result buffer. One request
// per cycle while req_stall is low; the whole sequencer step is one pass of
// logic from the request port and state registers into the result register.
// A two-entry result buffer keeps requests flowing while a result is stalled.
// Reset (synchronous, active high): sequence idle, timer zero, controlword 0,
// CSRs to 2000 / 100 / 20 ticks, result buffer empty.

module drive_power_enable_sequencer_unit
   import dpes_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_data
);

   localparam int CMP_BITS = (TIMER_BITS > WORD_BITS) ? TIMER_BITS : WORD_BITS;

   localparam logic [3:0] PH_IDLE         = 4'd0;
   localparam logic [3:0] PH_P1_HI        = 4'd1;
   localparam logic [3:0] PH_P1_LO        = 4'd2;
   localparam logic [3:0] PH_P2_HI        = 4'd3;
   localparam logic [3:0] PH_P2_LO        = 4'd4;
   localparam logic [3:0] PH_SETTLE1      = 4'd5;
   localparam logic [3:0] PH_WAIT_READY   = 4'd6;
   localparam logic [3:0] PH_WAIT_ON      = 4'd7;
   localparam logic [3:0] PH_WAIT_ENABLED = 4'd8;
   localparam logic [3:0] PH_SETTLE2      = 4'd9;

   logic [WORD_BITS-1:0]  step_timeout_ff;
   logic [WORD_BITS-1:0]  settle_ff;
   logic [WORD_BITS-1:0]  fault_pulse_ff;
   logic [3:0]            phase_ff;
   logic [3:0]            phase_in;
   logic [TIMER_BITS-1:0] timer_ff;
   logic [TIMER_BITS-1:0] timer_in;
   logic [WORD_BITS-1:0]  control_ff;
   logic [WORD_BITS-1:0]  control_in;

   logic                  req_accept;
   logic [3:0]            st;
   logic                  fault;
   logic                  wrote;
   logic [2:0]            status;
   logic [WORD_BITS-1:0]  limit;
   logic [TIMER_BITS-1:0] timer_inc;
   logic                  timer_done;
   rsp_type               result;
   logic                  buf_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_timeout_ff <= STEP_TIMEOUT_RESET;
         settle_ff       <= SETTLE_RESET;
         fault_pulse_ff  <= FAULT_PULSE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_STEP_TIMEOUT) step_timeout_ff <= csr_data;
         if (csr_index == CSR_SETTLE)       settle_ff       <= csr_data;
         if (csr_index == CSR_FAULT_PULSE)  fault_pulse_ff  <= csr_data;
      end
   end

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   assign st    = decode_state(req_data.status_word);
   assign fault = req_data.status_word[SW_FAULT_BIT];

   // pick the hold limit for the current phase
   always_comb begin
      unique case (phase_ff)
         PH_P1_HI, PH_P1_LO, PH_P2_HI, PH_P2_LO: limit = fault_pulse_ff;
         PH_SETTLE1, PH_SETTLE2:                 limit = settle_ff;
         default:                                limit = step_timeout_ff;
      endcase
   end

   // saturating count; a limit above the timer range ends at saturation
   assign timer_inc  = (&timer_ff) ? timer_ff : timer_ff + 1'b1;
   assign timer_done = (CMP_BITS'(timer_inc) >= CMP_BITS'(limit)) || (&timer_inc);

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      control_in = control_ff;
      wrote      = 1'b0;
      status     = STS_IDLE;
      if (req_data.mode == MODE_DISABLE) begin
         if (st == ST_ENABLED) control_in = CW_SHUTDOWN;
         phase_in = PH_IDLE;
         timer_in = '0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_data.mode == MODE_ENABLE) begin
                  status = STS_BUSY;
                  timer_in = '0;
                  if (fault) begin
                     control_in = CW_FAULT_RESET_SHUTDOWN;
                     phase_in = (req_data.drive_error_code == ERR_CLEARABLE) ?
                                PH_P1_HI : PH_P2_HI;
                  end else if (st == ST_ENABLED) begin
                     status = STS_REJECTED;
                  end else begin
                     wrote    = 1'b1;
                     phase_in = PH_SETTLE1;
                  end
               end
            end
            PH_P1_HI, PH_P2_HI: begin
               status   = STS_BUSY;
               timer_in = timer_inc;
               if (timer_done) begin
                  phase_in   = phase_ff + 4'd1;
                  control_in = CW_SHUTDOWN;
                  timer_in   = '0;
               end
            end
            PH_P1_LO, PH_P2_LO: begin
               status   = STS_BUSY;
               timer_in = timer_inc;
               if (timer_done) begin
                  timer_in = '0;
                  if (fault && phase_ff == PH_P1_LO) begin
                     phase_in   = PH_P2_HI;
                     control_in = CW_FAULT_RESET_SHUTDOWN;
                  end else if (fault || st == ST_ENABLED) begin
                     phase_in = PH_IDLE;
                     status   = STS_REJECTED;
                  end else begin
                     wrote    = 1'b1;
                     phase_in = PH_SETTLE1;
                  end
               end
            end
            PH_SETTLE1: begin
               status   = STS_BUSY;
               timer_in = timer_inc;
               if (timer_done) begin
                  phase_in   = PH_WAIT_READY;
                  control_in = CW_SHUTDOWN;
                  timer_in   = '0;
               end
            end
            PH_WAIT_READY, PH_WAIT_ON, PH_WAIT_ENABLED: begin
               status = STS_BUSY;
               if ((phase_ff == PH_WAIT_READY && st == ST_READY) ||
                   (phase_ff == PH_WAIT_ON && st == ST_ON) ||
                   (phase_ff == PH_WAIT_ENABLED && st == ST_ENABLED)) begin
                  phase_in = phase_ff + 4'd1;
                  timer_in = '0;
                  unique case (phase_ff)
                     PH_WAIT_READY: control_in = CW_SWITCH_ON;
                     PH_WAIT_ON:    control_in = CW_ENABLE_OP;
                     default:       control_in = CW_FINAL;
                  endcase
               end else if (timer_done) begin
                  phase_in = PH_IDLE;
                  timer_in = '0;
                  status   = STS_TIMEOUT;
               end else begin
                  timer_in = timer_inc;
               end
            end
            PH_SETTLE2: begin
               status   = STS_BUSY;
               timer_in = timer_inc;
               if (timer_done) begin
                  phase_in = PH_IDLE;
                  timer_in = '0;
                  status   = STS_DONE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               timer_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         control_ff <= CW_OFF;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         control_ff <= control_in;
      end
   end

   always_comb begin
      result.control_word    = control_in;
      result.target_write    = wrote;
      result.target_position = wrote ? req_data.actual_position : '0;
      result.sequence_status = status;
      result.decoded_state   = st;
      result.fault_seen      = fault;
   end

   dpes_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // the timer only runs inside a sequence
   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> timer_ff == '0)
      else $error("timer running while idle");

   a_disable_aborts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.mode == MODE_DISABLE |=> phase_ff == PH_IDLE)
      else $error("disable did not abort the sequence");

   a_copy_enters_settle: assert property (@(posedge clock) disable iff (reset)
      req_accept && result.target_write |=> phase_ff == PH_SETTLE1)
      else $error("position copy without settle phase");

   a_status_done_from_settle: assert property (@(posedge clock) disable iff (reset)
      req_accept && result.sequence_status == STS_DONE |-> phase_ff == PH_SETTLE2)
      else $error("enable finished outside final settle");

endmodule
